/* rtl/drmt_pkg.sv */
// Package for the dirty rectangle merge table: field widths, codes and the
// structs shared by the cells and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drmt_pkg;

  localparam int unsigned COORD_W   = 15;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COORD_W-1:0] SCREEN_W_RST = 15'd1024;
  localparam logic [COORD_W-1:0] SCREEN_H_RST = 15'd768;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_MERGED     = 3'd0,
    ACT_APPENDED   = 3'd1,
    ACT_OVERFLOW   = 3'd2,
    ACT_CLEARED    = 3'd3,
    ACT_READ_OK    = 3'd4,
    ACT_READ_EMPTY = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W = 1'b0,
    REG_SCREEN_H = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_MARK = 1'b0,
    OP_READ = 1'b1
  } probe_op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } entry_t;

  // Word travelling down the cell row, one cell per cycle.
  typedef struct packed {
    logic               valid;
    probe_op_e          op;
    logic               hit;
    logic [SLOT_W-1:0]  slot;   // read index, or slot of the merge
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  nr;     // right edge of the new rectangle
    logic [SIZE_W-1:0]  nb;     // bottom edge
    entry_t             res;
  } probe_t;

  typedef struct packed {
    action_e            action;
    logic [SLOT_W-1:0]  slot;
    entry_t             rect;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/drmt_if.sv */
// Handshake channels of the dirty rectangle merge table: command in,
// result out and configuration write. Depends on drmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface drmt_in_if import drmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [COORD_W-1:0] rect_w;
  logic [COORD_W-1:0] rect_h;
  logic [SLOT_W-1:0]  read_slot;

  modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, read_slot,
                  input ready);
  modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, read_slot,
                output ready);
endinterface

interface drmt_out_if import drmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [SLOT_W-1:0]  slot;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [SIZE_W-1:0]  out_w;
  logic [SIZE_W-1:0]  out_h;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, action, slot, out_x, out_y, out_w, out_h, entry_count,
                  input ready);
  modport sink (input valid, action, slot, out_x, out_y, out_w, out_h, entry_count,
                output ready);
endinterface

interface drmt_cfg_if import drmt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/drmt_cell.sv */
// One table cell: holds a single rectangle entry, tests the passing probe
// word against it and hands the word on. Depends on drmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drmt_cell import drmt_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire probe_t        probe_i,
  output      probe_t        probe_o,
  input  wire logic          wr_en_i,
  input  wire entry_t        wr_entry_i,
  input  wire logic [CW-1:0] count_i
);

  localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(IDX);

  entry_t ent_q, ent_d, mrg;
  probe_t probe_q, probe_d;
  logic [SIZE_W:0] er, eb, rx, by;
  logic [COORD_W-1:0] lx, ty;
  logic live, apart;

  always_comb begin
    er    = (SIZE_W+1)'(ent_q.x) + (SIZE_W+1)'(ent_q.w);
    eb    = (SIZE_W+1)'(ent_q.y) + (SIZE_W+1)'(ent_q.h);
    live  = IDX < 32'(count_i);
    // inclusive edges: touching counts as overlap
    apart = ((SIZE_W+1)'(probe_i.x) > er) || (probe_i.nr < SIZE_W'(ent_q.x)) ||
            ((SIZE_W+1)'(probe_i.y) > eb) || (probe_i.nb < SIZE_W'(ent_q.y));
    lx    = (probe_i.x < ent_q.x) ? probe_i.x : ent_q.x;
    ty    = (probe_i.y < ent_q.y) ? probe_i.y : ent_q.y;
    rx    = ((SIZE_W+1)'(probe_i.nr) > er) ? (SIZE_W+1)'(probe_i.nr) : er;
    by    = ((SIZE_W+1)'(probe_i.nb) > eb) ? (SIZE_W+1)'(probe_i.nb) : eb;
    mrg.x = lx;
    mrg.y = ty;
    mrg.w = SIZE_W'(rx - (SIZE_W+1)'(lx));
    mrg.h = SIZE_W'(by - (SIZE_W+1)'(ty));

    probe_d = probe_i;
    ent_d   = ent_q;
    if (probe_i.valid && !probe_i.hit && live) begin
      unique case (probe_i.op)
        OP_MARK: begin
          if (!apart) begin
            ent_d         = mrg;
            probe_d.hit   = 1'b1;
            probe_d.slot  = SLOT;
            probe_d.res   = mrg;
          end
        end
        OP_READ: begin
          if (32'(probe_i.slot) == IDX) begin
            probe_d.hit = 1'b1;
            probe_d.res = ent_q;
          end
        end
        default: ;
      endcase
    end
    if (wr_en_i) begin
      ent_d = wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

/* rtl/dirty_rect_merge_table_unit.sv */
// Dirty rectangle merge table, top level: command sequencer, screen size
// registers and the row of table cells. Depends on drmt_pkg, drmt_if, drmt_cell.
//
// A mark or read word is sent as a probe down a row of MAX_ENTRIES cells, one
// cell per cycle; the first held entry that overlaps or touches the new
// rectangle takes the union on the way, and a read picks its entry up as the
// probe passes. A mark or read result goes from the end of the cell row into a
// result register and, once the output register is free, into the output
// register; the next command is taken after that. A clear result goes through
// the same result register to the output register before the next command is
// taken; a command code of three is taken and dropped with no result.
// One command is in flight at a time; a finished result waits in the output
// register while the next command is accepted.
`timescale 1ns / 1ps
`default_nettype none

module dirty_rect_merge_table_unit import drmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drmt_in_if.sink   cmd_i,
  drmt_out_if.source res_o,
  drmt_cfg_if.sink  cfg_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  probe_t             inj_q, inj_d;
  entry_t             pend_q, pend_d;
  res_t               res_q, res_d;
  res_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] scr_w_q, scr_h_q;
  logic               wr_valid;
  logic [IW-1:0]      wr_idx;
  entry_t             wr_entry;
  probe_t             chain [MAX_ENTRIES+1];
  probe_t             pend_end;
  cmd_e               cmd;

  assign cmd      = cmd_e'(cmd_i.command);
  assign pend_end = chain[MAX_ENTRIES];
  assign chain[0] = inj_q;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_W_RST;
      scr_h_q <= SCREEN_H_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SCREEN_W: scr_w_q <= cfg_i.data;
        REG_SCREEN_H: scr_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    inj_d       = '0;
    pend_d      = pend_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    wr_valid    = 1'b0;
    wr_idx      = '0;
    wr_entry    = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          unique case (cmd)
            CMD_MARK: begin
              inj_d.valid = 1'b1;
              inj_d.op    = OP_MARK;
              inj_d.x     = cmd_i.rect_x;
              inj_d.y     = cmd_i.rect_y;
              inj_d.nr    = SIZE_W'(cmd_i.rect_x) + SIZE_W'(cmd_i.rect_w);
              inj_d.nb    = SIZE_W'(cmd_i.rect_y) + SIZE_W'(cmd_i.rect_h);
              pend_d.x    = cmd_i.rect_x;
              pend_d.y    = cmd_i.rect_y;
              pend_d.w    = SIZE_W'(cmd_i.rect_w);
              pend_d.h    = SIZE_W'(cmd_i.rect_h);
              state_d     = ST_SCAN;
            end
            CMD_READ: begin
              inj_d.valid = 1'b1;
              inj_d.op    = OP_READ;
              inj_d.slot  = cmd_i.read_slot;
              state_d     = ST_SCAN;
            end
            CMD_CLEAR: begin
              cnt_d        = '0;
              res_d.action = ACT_CLEARED;
              res_d.slot   = '0;
              res_d.rect   = '0;
              res_d.count  = '0;
              state_d      = ST_FINISH;
            end
            CMD_UNUSED: ;
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (pend_end.valid) begin
          state_d = ST_FINISH;
          if (pend_end.op == OP_READ) begin
            res_d.slot  = pend_end.slot;
            res_d.count = COUNT_W'(cnt_q);
            if (pend_end.hit) begin
              res_d.action = ACT_READ_OK;
              res_d.rect   = pend_end.res;
            end else begin
              res_d.action = ACT_READ_EMPTY;
              res_d.rect   = '0;
            end
          end else if (pend_end.hit) begin
            res_d.action = ACT_MERGED;
            res_d.slot   = pend_end.slot;
            res_d.rect   = pend_end.res;
            res_d.count  = COUNT_W'(cnt_q);
          end else if (32'(cnt_q) >= MAX_ENTRIES) begin
            // table full: collapse to one full-screen entry
            wr_valid     = 1'b1;
            wr_idx       = '0;
            wr_entry.x   = '0;
            wr_entry.y   = '0;
            wr_entry.w   = SIZE_W'(scr_w_q);
            wr_entry.h   = SIZE_W'(scr_h_q);
            cnt_d        = CW'(1);
            res_d.action = ACT_OVERFLOW;
            res_d.slot   = '0;
            res_d.rect   = wr_entry;
            res_d.count  = COUNT_W'(1);
          end else begin
            wr_valid     = 1'b1;
            wr_idx       = IW'(cnt_q);
            cnt_d        = cnt_q + CW'(1);
            res_d.action = ACT_APPENDED;
            res_d.slot   = SLOT_W'(cnt_q);
            res_d.rect   = pend_q;
            res_d.count  = COUNT_W'(cnt_d);
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    drmt_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (chain[k]),
      .probe_o    (chain[k+1]),
      .wr_en_i    (wr_valid && (wr_idx == IW'(k))),
      .wr_entry_i (wr_entry),
      .count_i    (cnt_q)
    );
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.action      = out_q.action;
  assign res_o.slot        = out_q.slot;
  assign res_o.out_x       = out_q.rect.x;
  assign res_o.out_y       = out_q.rect.y;
  assign res_o.out_w       = out_q.rect.w;
  assign res_o.out_h       = out_q.rect.h;
  assign res_o.entry_count = out_q.count;

endmodule

`default_nettype wire

/* rtl/drmt_checker.sv */
// Port-level checks on the result channel of the dirty rectangle merge table,
// bound to the top level. Depends on drmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drmt_checker import drmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [ACT_W-1:0]   action,
  input wire logic [SLOT_W-1:0]  slot,
  input wire logic [COORD_W-1:0] out_x,
  input wire logic [COORD_W-1:0] out_y,
  input wire logic [SIZE_W-1:0]  out_w,
  input wire logic [SIZE_W-1:0]  out_h,
  input wire logic [COUNT_W-1:0] entry_count
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> 32'(entry_count) <= MAX_ENTRIES)
    else $error("entry count beyond table depth");

  a_clear_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && action == ACT_CLEARED) |->
      (slot == '0 && entry_count == '0 && out_x == '0 && out_y == '0 &&
       out_w == '0 && out_h == '0))
    else $error("clear word not empty");

  a_overflow_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && action == ACT_OVERFLOW) |->
      (slot == '0 && entry_count == COUNT_W'(1) && out_x == '0 && out_y == '0))
    else $error("overflow word malformed");

  a_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && action == ACT_READ_EMPTY) |->
      (out_x == '0 && out_y == '0 && out_w == '0 && out_h == '0))
    else $error("empty read carries a rectangle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(action) && $stable(out_w)))
    else $error("stalled result word changed");

endmodule

bind dirty_rect_merge_table_unit drmt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_drmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid   (res_o.valid),
  .res_ready   (res_o.ready),
  .action      (res_o.action),
  .slot        (res_o.slot),
  .out_x       (res_o.out_x),
  .out_y       (res_o.out_y),
  .out_w       (res_o.out_w),
  .out_h       (res_o.out_h),
  .entry_count (res_o.entry_count)
);

`default_nettype wire

/* tb/dirty_rect_merge_table_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for dirty_rect_merge_table_unit: drives mark, clear and
// read commands plus screen-size writes, predicts every result word and checks it.
// Depends on drmt_pkg, drmt_if and the RTL top level.

module dirty_rect_merge_table_unit_tb;
  import drmt_pkg::*;

  localparam int unsigned MAX_ENTRIES   = 16;
  localparam int unsigned IDX_W         = $clog2(MAX_ENTRIES);
  localparam int unsigned SETTLE_CYCLES = MAX_ENTRIES + 8;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    cmd_e               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [SLOT_W-1:0]  rs;
  } cmd_word_t;

  logic clk_i;
  logic rst_ni;

  drmt_in_if  cmd_if ();
  drmt_out_if res_if ();
  drmt_cfg_if cfg_if ();

  dirty_rect_merge_table_unit #(.MAX_ENTRIES(MAX_ENTRIES)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // predicted table contents and screen size
  entry_t             rect_tab [MAX_ENTRIES];
  int unsigned        tab_count;
  logic [COORD_W-1:0] scr_w;
  logic [COORD_W-1:0] scr_h;
  res_t               expect_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned errors;
  int unsigned n_settings;
  int unsigned quiet_cycles = 0;
  int unsigned act_seen [6];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cmd_word_t make_cmd(cmd_e c, int unsigned x, int unsigned y,
                                         int unsigned w, int unsigned h,
                                         int unsigned rs);
    cmd_word_t wd;
    wd.cmd = c;
    wd.x   = COORD_W'(x);
    wd.y   = COORD_W'(y);
    wd.w   = COORD_W'(w);
    wd.h   = COORD_W'(h);
    wd.rs  = SLOT_W'(rs);
    return wd;
  endfunction

  // Works out the answer to one accepted word and updates the predicted table.
  function automatic void predict_result(cmd_word_t wd);
    logic [SIZE_W:0]  nx, ny, nr, nb, ex, ey, er, eb, lx, ty, rx, by;
    logic [IDX_W-1:0] ix;
    res_t r;
    bit   hit;
    hit = 1'b0;
    r   = '0;
    nx  = (SIZE_W+1)'(wd.x);
    ny  = (SIZE_W+1)'(wd.y);
    nr  = nx + (SIZE_W+1)'(wd.w);
    nb  = ny + (SIZE_W+1)'(wd.h);
    case (wd.cmd)
      CMD_MARK: begin
        for (int i = 0; i < tab_count; i++) begin
          ix = IDX_W'(i);
          ex = (SIZE_W+1)'(rect_tab[ix].x);
          ey = (SIZE_W+1)'(rect_tab[ix].y);
          er = ex + (SIZE_W+1)'(rect_tab[ix].w);
          eb = ey + (SIZE_W+1)'(rect_tab[ix].h);
          // inclusive edges: touching counts as overlap
          if (!hit && !(nx > er || nr < ex || ny > eb || nb < ey)) begin
            lx = (nx < ex) ? nx : ex;
            ty = (ny < ey) ? ny : ey;
            rx = (nr > er) ? nr : er;
            by = (nb > eb) ? nb : eb;
            rect_tab[ix].x = lx[COORD_W-1:0];
            rect_tab[ix].y = ty[COORD_W-1:0];
            rect_tab[ix].w = SIZE_W'(rx - lx);
            rect_tab[ix].h = SIZE_W'(by - ty);
            r.action = ACT_MERGED;
            r.slot   = SLOT_W'(i);
            r.rect   = rect_tab[ix];
            hit      = 1'b1;
          end
        end
        if (!hit && tab_count >= MAX_ENTRIES) begin
          rect_tab[0].x = '0;
          rect_tab[0].y = '0;
          rect_tab[0].w = SIZE_W'(scr_w);
          rect_tab[0].h = SIZE_W'(scr_h);
          tab_count = 1;
          r.action  = ACT_OVERFLOW;
          r.slot    = '0;
          r.rect    = rect_tab[0];
        end else if (!hit) begin
          ix = IDX_W'(tab_count);
          rect_tab[ix].x = wd.x;
          rect_tab[ix].y = wd.y;
          rect_tab[ix].w = SIZE_W'(wd.w);
          rect_tab[ix].h = SIZE_W'(wd.h);
          r.action = ACT_APPENDED;
          r.slot   = SLOT_W'(tab_count);
          r.rect   = rect_tab[ix];
          tab_count++;
        end
        r.count = COUNT_W'(tab_count);
        expect_q.push_back(r);
      end
      CMD_CLEAR: begin
        tab_count = 0;
        r.action  = ACT_CLEARED;
        expect_q.push_back(r);
      end
      CMD_READ: begin
        r.slot  = wd.rs;
        r.count = COUNT_W'(tab_count);
        if (32'(wd.rs) < tab_count) begin
          r.action = ACT_READ_OK;
          r.rect   = rect_tab[IDX_W'(wd.rs)];
        end else begin
          r.action = ACT_READ_EMPTY;
        end
        expect_q.push_back(r);
      end
      default: ;  // code three is dropped without an answer
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    res_t want;
    if (expect_q.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, actual action %0d slot %0d",
               $time, res_if.action, res_if.slot);
    end else begin
      want = expect_q.pop_front();
      check_field("action", 32'(want.action), 32'(res_if.action));
      check_field("slot", 32'(want.slot), 32'(res_if.slot));
      check_field("out_x", 32'(want.rect.x), 32'(res_if.out_x));
      check_field("out_y", 32'(want.rect.y), 32'(res_if.out_y));
      check_field("out_w", 32'(want.rect.w), 32'(res_if.out_w));
      check_field("out_h", 32'(want.rect.h), 32'(res_if.out_h));
      check_field("entry_count", 32'(want.count), 32'(res_if.entry_count));
      act_seen[want.action]++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_word();
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("[dirty_rect_merge_table_unit] ERROR");
    $finish;
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Entered and left at a falling edge; valid stays high between back-to-back words.
  task automatic send_word(cmd_word_t wd);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= wd.cmd;
    cmd_if.rect_x    <= wd.x;
    cmd_if.rect_y    <= wd.y;
    cmd_if.rect_w    <= wd.w;
    cmd_if.rect_h    <= wd.h;
    cmd_if.read_slot <= wd.rs;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    predict_result(wd);
    @(negedge clk_i);
  endtask

  // Code three gives no answer, so allow the block to finish after the last result.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_screen(logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
    wait_drained();
    for (int k = 0; k < 2; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= (k == 0) ? REG_SCREEN_W : REG_SCREEN_H;
      cfg_if.data  <= (k == 0) ? w : h;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      if (k == 0) scr_w = w;
      else scr_h = h;
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // style 0-3: clustered marks that merge; 4-7: spread out so the table fills;
  // 8-9: anywhere in the coordinate range
  function automatic cmd_word_t random_cmd(int unsigned style);
    cmd_word_t   wd;
    int unsigned pick;
    pick = $urandom_range(99);
    wd = make_cmd(CMD_MARK, $urandom_range(32767), $urandom_range(32767),
                  $urandom_range(32767), $urandom_range(32767), $urandom_range(15));
    if (pick < 3) begin
      wd.cmd = CMD_UNUSED;
    end else if (pick < 7) begin
      wd.cmd = CMD_CLEAR;
    end else if (pick < 27) begin
      wd.cmd = CMD_READ;
      if ($urandom_range(1) && tab_count > 0) wd.rs = SLOT_W'($urandom_range(tab_count - 1));
    end else if (style < 4) begin
      wd.x = COORD_W'($urandom_range(400));
      wd.y = COORD_W'($urandom_range(400));
      wd.w = COORD_W'($urandom_range(40));
      wd.h = COORD_W'($urandom_range(40));
    end else if (style < 8) begin
      wd.x = COORD_W'($urandom_range(15) * 2048 + $urandom_range(100));
      wd.y = COORD_W'($urandom_range(15) * 2048 + $urandom_range(100));
      wd.w = COORD_W'($urandom_range(200));
      wd.h = COORD_W'($urandom_range(200));
    end
    return wd;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 0));                  // empty table
    send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 15));
    send_word(make_cmd(CMD_MARK, 0, 0, 0, 0, 0));                  // zero-size point
    send_word(make_cmd(CMD_MARK, 0, 0, 0, 0, 0));                  // same point merges
    send_word(make_cmd(CMD_MARK, 5, 5, 3, 3, 0));
    send_word(make_cmd(CMD_MARK, 8, 8, 0, 0, 0));                  // touches a corner
    send_word(make_cmd(CMD_MARK, 9, 0, 2, 2, 0));                  // one pixel apart
    send_word(make_cmd(CMD_MARK, 32767, 32767, 32767, 32767, 0));  // largest edges
    send_word(make_cmd(CMD_MARK, 0, 32767, 32767, 0, 0));          // widest union
    for (int i = 0; i < 5; i++) send_word(make_cmd(CMD_READ, 0, 0, 0, 0, i));
    send_word(make_cmd(CMD_UNUSED, $urandom_range(32767), $urandom_range(32767),
                       $urandom_range(32767), $urandom_range(32767), $urandom_range(15)));
    send_word(make_cmd(CMD_MARK, 0, 0, 10, 10, 0));                // first match only
    send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
    send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 1));
    send_word(make_cmd(CMD_CLEAR, 32767, 32767, 32767, 32767, 15));
    send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
    send_word(make_cmd(CMD_MARK, 100, 200, 300, 400, 0));
    send_word(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
  endtask

  // Fill the table with disjoint marks, then one more collapses it to the screen.
  task automatic test_screen_sizes();
    logic [COORD_W-1:0] widths  [5] = '{15'd1, 15'd32767, 15'd1, 15'd32767, SCREEN_W_RST};
    logic [COORD_W-1:0] heights [5] = '{15'd1, 15'd32767, 15'd32767, 15'd1, SCREEN_H_RST};
    for (int s = 0; s < 5; s++) begin
      set_screen(widths[s], heights[s]);
      send_word(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
      for (int i = 0; i <= MAX_ENTRIES; i++) begin
        send_word(make_cmd(CMD_MARK, i * 40 + $urandom_range(5), $urandom_range(32767),
                           $urandom_range(30), $urandom_range(32767), $urandom_range(15)));
      end
      send_word(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
      send_word(make_cmd(CMD_MARK, 0, 0, 0, 0, 0));
    end
  endtask

  task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
    int unsigned sent;
    int unsigned style;
    cmd_word_t   wd;
    set_screen(COORD_W'($urandom_range(1, 32767)), COORD_W'($urandom_range(1, 32767)));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      style = $urandom_range(9);
      repeat ($urandom_range(8, 40)) begin
        wd = random_cmd(style);
        send_word(wd);
        if (wd.cmd != CMD_UNUSED) sent++;
      end
    end
  endtask

  // Result side held off while words keep coming, then a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_word(random_cmd($urandom_range(9)));
    wait_drained();
  endtask

  initial begin
    errors        = 0;
    n_settings    = 0;
    hold_req      = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 61;
    tab_count     = 0;
    scr_w         = SCREEN_W_RST;
    scr_h         = SCREEN_H_RST;
    foreach (act_seen[i]) act_seen[i] = 0;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_MARK;
    cmd_if.rect_x    = '0;
    cmd_if.rect_y    = '0;
    cmd_if.rect_w    = '0;
    cmd_if.rect_h    = '0;
    cmd_if.read_slot = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_SCREEN_W;
    cfg_if.data      = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_screen_sizes();
    test_random(480, 22, 61);
    test_random(480, 61, 22);
    test_backpressure();
    test_random(480, 0, 0);
    wait_drained();

    $display("Checked %0d merges, %0d appends, %0d overflows, %0d clears,",
             act_seen[ACT_MERGED], act_seen[ACT_APPENDED], act_seen[ACT_OVERFLOW],
             act_seen[ACT_CLEARED]);
    $display("%0d reads of held entries and %0d empty reads over %0d screen sizes.",
             act_seen[ACT_READ_OK], act_seen[ACT_READ_EMPTY], n_settings);
    if (errors == 0) begin
      $display("[dirty_rect_merge_table_unit] OK");
    end else begin
      $display("[dirty_rect_merge_table_unit] ERROR");
    end
    $finish;
  end

endmodule
